>>> design/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// No dependencies; imported by the top level.
package sle_pkg;

  // Field widths of the request and result items
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_HEAD,
    S_DEL_SHIFT,
    S_FIND
  } state_t;

endpackage

>>> design/sequential_list_engine.sv
// Sequential list engine: ordered list of signed 32-bit entries in one RAM.
// Depends on sle_pkg and sle_ram.
//
// The block holds up to CAPACITY signed 32-bit entries in a RAM with one write
// and one read port (registered read) plus an entry count, and takes one
// request item at a time. Update, append (insert at the end) and every rejected
// request finish in the cycle they are accepted. Insert at position p moves the
// entries from the end down to p up by one, then writes the new value; delete at
// p reads entry p, then moves the entries above it down by one; a find scans from
// index 0 up to the first match or the end of the list. Every moved entry costs
// one RAM read and one write, one entry per cycle. A finished result passes
// through a holding register to the output register. The input stays closed
// while the holding register is full, so the next item is taken only once the
// previous result has moved on to the output register, while that result may
// still wait for out_ready there. Entries are never cleared; only entries below
// the count are ever used.
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_operation,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VAL_W-1:0]    in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IDX_W-1:0]           out_found_index,
  output logic signed [VAL_W-1:0]    out_removed_value,
  output logic [CNT_W-1:0]           out_entry_count
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int FW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int NW  = (CW > CNT_W) ? CW : CNT_W;

  // Sequencer and request registers
  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [VAL_W-1:0]         val_r, val_nxt;
  logic [VAL_W-1:0]         removed_r, removed_nxt;

  // Result holding register and output register
  logic                     res_valid_r, res_valid_nxt;
  status_t                  res_status_r;
  logic [IDX_W-1:0]         res_found_r;
  logic [VAL_W-1:0]         res_removed_r;
  logic [CNT_W-1:0]         res_count_r;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r;
  logic [IDX_W-1:0]         out_found_r;
  logic [VAL_W-1:0]         out_removed_r;
  logic [CNT_W-1:0]         out_count_r;

  // Finish strobe and result fields
  logic                     fin;
  status_t                  fin_status;
  logic [AW-1:0]            fin_found;
  logic [VAL_W-1:0]         fin_removed;
  logic                     move;

  // RAM ports
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [VAL_W-1:0]         ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [VAL_W-1:0]         ram_rdata;

  // Helpers
  logic                     accept;
  op_t                      in_op;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [AW-1:0]            km1;
  logic [FW-1:0]            found_ext;
  logic [NW-1:0]            count_ext;

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !res_valid_r;
  assign accept   = in_valid && in_ready;
  assign in_op    = op_t'(in_operation);
  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);
  assign km1      = k_r - AW'(1);

  // Next state, RAM accesses and result
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_found   = '0;
    fin_removed = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          pos_nxt = pos_ext[AW-1:0];
          if (in_op == OP_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else if (pos_ext == cnt_ext) begin
              // append: no entries to move
              ram_we     = 1'b1;
              ram_waddr  = pos_ext[AW-1:0];
              ram_wdata  = in_value;
              count_nxt  = count_r + CW'(1);
              fin        = 1'b1;
            end else begin
              ram_raddr  = AW'(count_r - CW'(1));
              k_nxt      = AW'(count_r);
              state_nxt  = S_INS_SHIFT;
            end
          end else if (count_r == '0) begin
            fin        = 1'b1;
            fin_status = ST_EMPTY;
          end else if (in_op == OP_FIND) begin
            ram_raddr = '0;
            k_nxt     = '0;
            state_nxt = S_FIND;
          end else if (pos_ext >= cnt_ext) begin
            fin        = 1'b1;
            fin_status = ST_BADPOS;
          end else if (in_op == OP_DELETE) begin
            ram_raddr = pos_ext[AW-1:0];
            state_nxt = S_DEL_HEAD;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pos_ext[AW-1:0];
            ram_wdata = in_value;
            fin       = 1'b1;
          end
        end
      end
      S_INS_SHIFT: begin
        // entry k-1 moves up to k
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
        ram_raddr = km1 - AW'(1);
        if (km1 == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          k_nxt = km1;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DEL_HEAD: begin
        removed_nxt = ram_rdata;
        k_nxt       = pos_r;
        if (CW'(pos_r) + CW'(1) < count_r) begin
          ram_raddr = AW'(CW'(pos_r) + CW'(1));
          state_nxt = S_DEL_SHIFT;
        end else begin
          count_nxt   = count_r - CW'(1);
          fin         = 1'b1;
          fin_removed = ram_rdata;
          state_nxt   = S_IDLE;
        end
      end
      S_DEL_SHIFT: begin
        // entry k+1 moves down to k
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
        if (CW'(k_r) + CW'(2) < count_r) begin
          ram_raddr = AW'(CW'(k_r) + CW'(2));
          k_nxt     = k_r + AW'(1);
        end else begin
          count_nxt   = count_r - CW'(1);
          fin         = 1'b1;
          fin_removed = removed_r;
          state_nxt   = S_IDLE;
        end
      end
      S_FIND: begin
        if (ram_rdata == val_r) begin
          fin       = 1'b1;
          fin_found = k_r;
          state_nxt = S_IDLE;
        end else if (CW'(k_r) + CW'(1) < count_r) begin
          ram_raddr = AW'(CW'(k_r) + CW'(1));
          k_nxt     = k_r + AW'(1);
        end else begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign found_ext = FW'(fin_found);
  assign count_ext = NW'(count_nxt);

  // Result hand-off: holding register to output register
  assign move          = res_valid_r && (!out_valid_r || out_ready);
  assign res_valid_nxt = fin ? 1'b1 : (move ? 1'b0 : res_valid_r);
  assign out_valid_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    removed_r <= removed_nxt;
    if (fin) begin
      res_status_r  <= fin_status;
      res_found_r   <= found_ext[IDX_W-1:0];
      res_removed_r <= fin_removed;
      res_count_r   <= count_ext[CNT_W-1:0];
    end
    if (move) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_removed_r <= res_removed_r;
      out_count_r   <= res_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_index   = out_found_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

`ifndef SYNTH
  // A finished result never overwrites one still held
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !res_valid_r)
    else $error("result finished while holding register full");

  // The count moves by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1))))
    else $error("entry count jumped");

  // The count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // RAM writes stay inside the list
  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) <= count_r))
    else $error("RAM write beyond the end of the list");
`endif

endmodule

>>> design/sle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the entry being written returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/tb_top.sv
// Testbench for sequential_list_engine: directed table, then random requests.
// Depends on sle_pkg and the sequential_list_engine RTL; self-checking.
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  localparam int LIST_CAP       = 16;
  localparam int ITEMS_PER_MODE = 355;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    status_t            status;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] removed;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  typedef struct {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic signed [31:0] val;
    int                 reps;
    bit                 typed;
    list_result_t       res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_operation = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [IDX_W-1:0]        out_found_index;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [CNT_W-1:0]        out_entry_count;

  // shadow copy of the list, updated when a request is accepted
  logic signed [31:0] list_model [0:LIST_CAP-1];
  int                 list_len = 0;
  list_result_t       pending_results [$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  bit  growing = 1'b1;

  sequential_list_engine #(.CAPACITY(LIST_CAP)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predict one request and update the shadow list
  function automatic list_result_t apply_request(op_t op, logic [POS_W-1:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    int k;
    bit hit;
    r.status  = ST_OK;
    r.idx     = '0;
    r.removed = '0;
    hit = 1'b0;
    if (op == OP_INSERT) begin
      if (list_len >= LIST_CAP) begin
        r.status = ST_FULL;
      end else if (int'(pos) > list_len) begin
        r.status = ST_BADPOS;
      end else begin
        for (k = list_len; k > int'(pos); k--) list_model[k] = list_model[k-1];
        list_model[pos] = val;
        list_len++;
      end
    end else if (list_len == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_FIND) begin
      r.status = ST_NOTFOUND;
      for (k = 0; k < list_len; k++) begin
        if (!hit && list_model[k] == val) begin
          hit = 1'b1;
          r.status = ST_OK;
          r.idx = k[IDX_W-1:0];
        end
      end
    end else if (int'(pos) >= list_len) begin
      r.status = ST_BADPOS;
    end else if (op == OP_DELETE) begin
      r.removed = list_model[pos];
      for (k = int'(pos); k < list_len - 1; k++) list_model[k] = list_model[k+1];
      list_len--;
    end else begin
      list_model[pos] = val;
    end
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  // Value source: repeats and extremes so finds hit and duplicates occur
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 32'(signed'($urandom_range(7)) - 3);
    if (r < 40) return ($urandom_range(1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Present one item and wait for it to be taken
  task automatic offer_item(op_t op, logic [POS_W-1:0] pos, logic signed [31:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no request pending");
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_status != e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          err_cnt++;
        end
        if (out_found_index != e.idx) begin
          $error("found_index: expected %0d, got %0d", e.idx, out_found_index);
          err_cnt++;
        end
        if (out_removed_value != e.removed) begin
          $error("removed_value: expected %0d, got %0d", e.removed, out_removed_value);
          err_cnt++;
        end
        if (out_entry_count != e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_entry_count);
          err_cnt++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [0:17];
    list_result_t res;
    op_t op;
    logic [POS_W-1:0] pos;
    logic signed [31:0] val;
    int i, j, mode, r;

    // typed rows follow the list by hand: [-1, max, min] after the three inserts
    dir_tab = '{
      '{OP_DELETE, 4'd0,  32'sd0,            1, 1'b1, '{ST_EMPTY,    4'd0, 32'sd0, 5'd0}},
      '{OP_FIND,   4'd0,  32'sd0,            1, 1'b1, '{ST_EMPTY,    4'd0, 32'sd0, 5'd0}},
      '{OP_UPDATE, 4'd0,  32'sd9,            1, 1'b1, '{ST_EMPTY,    4'd0, 32'sd0, 5'd0}},
      '{OP_INSERT, 4'd1,  32'sd5,            1, 1'b1, '{ST_BADPOS,   4'd0, 32'sd0, 5'd0}},
      '{OP_INSERT, 4'd0,  32'sh7fff_ffff,    1, 1'b1, '{ST_OK,       4'd0, 32'sd0, 5'd1}},
      '{OP_INSERT, 4'd1,  32'sh8000_0000,    1, 1'b1, '{ST_OK,       4'd0, 32'sd0, 5'd2}},
      '{OP_INSERT, 4'd0,  -32'sd1,           1, 1'b1, '{ST_OK,       4'd0, 32'sd0, 5'd3}},
      '{OP_FIND,   4'd9,  32'sh8000_0000,    1, 1'b1, '{ST_OK,       4'd2, 32'sd0, 5'd3}},
      '{OP_FIND,   4'd0,  32'sd5,            1, 1'b1, '{ST_NOTFOUND, 4'd0, 32'sd0, 5'd3}},
      '{OP_UPDATE, 4'd3,  32'sd7,            1, 1'b1, '{ST_BADPOS,   4'd0, 32'sd0, 5'd3}},
      '{OP_DELETE, 4'd15, 32'sd0,            1, 1'b1, '{ST_BADPOS,   4'd0, 32'sd0, 5'd3}},
      '{OP_UPDATE, 4'd1,  32'sd0,            1, 1'b1, '{ST_OK,       4'd0, 32'sd0, 5'd3}},
      '{OP_DELETE, 4'd1,  32'sd0,            1, 1'b1, '{ST_OK,       4'd0, 32'sd0, 5'd2}},
      // fill to capacity by pushing at the head
      '{OP_INSERT, 4'd0,  32'sh0000_1000,   14, 1'b0, '{ST_OK,       4'd0, 32'sd0, 5'd0}},
      '{OP_INSERT, 4'd0,  32'sd3,            1, 1'b1, '{ST_FULL,     4'd0, 32'sd0, 5'd16}},
      '{OP_DELETE, 4'd15, 32'sd0,            1, 1'b1,
        '{ST_OK, 4'd0, 32'sh8000_0000, 5'd15}},
      '{OP_FIND,   4'd0,  -32'sd1,           1, 1'b1, '{ST_OK,       4'd14, 32'sd0, 5'd15}},
      '{OP_INSERT, 4'd15, 32'sh5555_5555,    1, 1'b0, '{ST_OK,       4'd0, 32'sd0, 5'd0}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < 18; i++) begin
      for (j = 0; j < dir_tab[i].reps; j++) begin
        val = dir_tab[i].val + j;
        offer_item(dir_tab[i].op, dir_tab[i].pos, val);
        res = apply_request(dir_tab[i].op, dir_tab[i].pos, val);
        pending_results.push_back(dir_tab[i].typed ? dir_tab[i].res : res);
      end
    end

    // random requests, one idling mode per phase
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 80; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 80; end
        default: begin in_idle_pct = 38; out_stall_pct = 38; end
      endcase
      for (i = 0; i < ITEMS_PER_MODE; i++) begin
        // sweep the fill level up and down between empty and full
        if (list_len >= LIST_CAP) growing = 1'b0;
        else if (list_len == 0) growing = 1'b1;
        else if ($urandom_range(99) < 2) growing = !growing;

        r = $urandom_range(99);
        if (r < 5) begin
          // noise: every field fully random
          op  = op_t'($urandom_range(3));
          pos = POS_W'($urandom_range(15));
          val = $urandom;
        end else begin
          r = $urandom_range(99);
          if (r < 55) op = growing ? OP_INSERT : OP_DELETE;
          else if (r < 70) op = growing ? OP_DELETE : OP_INSERT;
          else if (r < 85) op = OP_FIND;
          else op = OP_UPDATE;

          if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(15));
          else if (op == OP_INSERT) pos = POS_W'($urandom_range(list_len > 15 ? 15 : list_len));
          else pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;

          if (op == OP_FIND && list_len > 0 && $urandom_range(99) < 60)
            val = list_model[$urandom_range(list_len - 1)];
          else
            val = pick_value();
        end
        offer_item(op, pos, val);
        pending_results.push_back(apply_request(op, pos, val));
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
